// ----- hdl/bamt_pkg.sv -----
// Shared constants and types for the breakpoint address match table.
package bamt_pkg;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned OFFSET_BITS = 23;
  localparam int unsigned CNT_W       = $clog2(ENTRIES + 1);
  localparam int unsigned IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [IDX_W-1:0]       index_t;

  typedef enum logic [1:0] {
    MODE_TEST   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

endpackage

// ----- hdl/bamt_if.sv -----
// Valid/ready word channels for requests and results of the match table.
interface bamt_req_if import bamt_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  offset_t     rom_offset;

  modport source (output valid, output mode, output rom_offset, input ready);
  modport sink   (input valid, input mode, input rom_offset, output ready);
endinterface

interface bamt_rsp_if import bamt_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        ok;
  offset_t     matched_offset;
  count_t      entry_count;

  modport source (output valid, output ok, output matched_offset, output entry_count,
                  input ready);
  modport sink   (input valid, input ok, input matched_offset, input entry_count,
                  output ready);
endinterface

// ----- hdl/breakpoint_address_match_table.sv -----
// Breakpoint address match table: parallel-compare offset store with add, remove, test, clear.
// Result: the result word is registered when the request word is taken.
// Throughput: one request per cycle while the result word is taken; all entries are compared in parallel,
// and the result register frees itself in the same cycle its word is taken.
// Reset: asynchronous active low; empties the table and the result register.
// Table entries have no reset; only the first entry_count entries are ever compared or read.
module breakpoint_address_match_table import bamt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bamt_req_if.sink   req_i,
  bamt_rsp_if.source rsp_o
);

  offset_t            table_q [ENTRIES];
  count_t             count_q, count_d;
  logic               out_valid_q;
  logic               ok_q, ok_d;
  offset_t            match_q, match_d;
  count_t             cnt_out_q;
  logic [ENTRIES-1:0] hit_vec;
  logic               hit, accept, add_en, rem_en;
  mode_e              mode;
  offset_t            key, last_val;
  count_t             last_cnt;

  assign mode     = mode_e'(req_i.mode);
  assign key      = req_i.rom_offset;
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept   = req_i.valid && req_i.ready;
  assign last_cnt = count_q - count_t'(1);
  assign last_val = table_q[last_cnt[IDX_W-1:0]];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = (count_t'(i) < count_q) && (table_q[i] == key);
    end
  end

  assign hit = |hit_vec;

  always_comb begin
    count_d = count_q;
    ok_d    = 1'b0;
    match_d = '0;
    add_en  = 1'b0;
    rem_en  = 1'b0;
    case (mode)
      MODE_TEST: begin
        ok_d    = hit;
        match_d = hit ? key : '0;
      end
      MODE_ADD: begin
        if (!hit && (count_q < count_t'(ENTRIES))) begin
          add_en  = 1'b1;
          ok_d    = 1'b1;
          count_d = count_q + count_t'(1);
        end
      end
      MODE_REMOVE: begin
        if (hit) begin
          rem_en  = 1'b1;
          ok_d    = 1'b1;
          count_d = last_cnt;
        end
      end
      MODE_CLEAR: begin
        ok_d    = 1'b1;
        count_d = '0;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (add_en && (count_q[IDX_W-1:0] == index_t'(i))) begin
          table_q[i] <= key;
        end else if (rem_en && hit_vec[i]) begin
          table_q[i] <= last_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q      <= ok_d;
      match_q   <= match_d;
      cnt_out_q <= count_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.ok             = ok_q;
  assign rsp_o.matched_offset = match_q;
  assign rsp_o.entry_count    = cnt_out_q;

endmodule
